### src/segbox_pkg.sv
// Shared constants and helpers for the segment versus box edge crossing block.
// Used by every pipeline stage, the top level and the testbench; no dependencies.
package segbox_pkg;

  localparam int NUM_EDGES = 4;

  typedef enum logic [1:0] {
    EDGE_RIGHT  = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_LEFT   = 2'd2,
    EDGE_TOP    = 2'd3
  } edge_e;

  function automatic logic edge_is_vertical(edge_e e);
    logic v;
    unique case (e)
      EDGE_RIGHT, EDGE_LEFT: v = 1'b1;
      default:               v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

### src/segbox_if.sv
// Valid/ready channel interfaces for segment-box beats and hit results.
// Widths follow COORD_BITS; no package dependency.
interface segbox_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] box_center_x;
  logic signed [COORD_BITS-1:0] box_center_y;
  logic        [COORD_BITS-2:0] box_half_w;
  logic        [COORD_BITS-2:0] box_half_h;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_center_x, box_center_y, box_half_w, box_half_h,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_center_x, box_center_y, box_half_w, box_half_h,
    output ready
  );
endinterface

interface segbox_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

### src/segment_box_edge_intersect_top.sv
// Segment versus axis-aligned box edge crossing test, top level.
// Depends on segbox_pkg, segbox_if, segbox_prep, segbox_mul and segbox_cmp.
//
// Usage:
//   in_i carries one beat per segment-box pair: segment start and end points
//   and a box given as centre plus half width and half height (signed
//   COORD_BITS-bit coordinates, unsigned half sizes one bit narrower, any binary point).
//   out_o carries one beat per input beat, in order: hit is 1 when the segment
//   touches or crosses any of the four box edges, with edges parallel to the
//   segment never counting.
// Timing:
//   Three register stages (operand prep, cross products, compare and OR).
//   A result reaches out_o through the prep, multiply and compare registers.
//   One beat per cycle is sustained while out_o is ready, since each stage loads a new
//   beat as its own moves on; products are at most 18x17 bits at 16 bits.
// Reset and stall:
//   Reset clears all stage valid bits; nothing is in flight afterwards.
//   When out_o stalls, each stage holds its beat and empty stages still fill,
//   so in_i keeps accepting until every stage holds a beat.
module segment_box_edge_intersect_top #(
  parameter int COORD_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  segbox_in_if.sink    in_i,
  segbox_out_if.source out_o
);

  localparam int NE = segbox_pkg::NUM_EDGES;

  logic                           s1_valid, s1_ready;
  logic                           s2_valid, s2_ready;
  logic signed [COORD_BITS:0]     s1_rx, s1_ry;
  logic signed [COORD_BITS:0]     s1_a  [NE];
  logic signed [COORD_BITS+1:0]   s1_b  [NE];
  logic signed [COORD_BITS:0]     s1_k  [NE];
  logic signed [COORD_BITS+1:0]   s1_qx [NE];
  logic signed [COORD_BITS+1:0]   s1_qy [NE];
  logic signed [2*COORD_BITS+1:0] s2_den [NE];
  logic signed [2*COORD_BITS+2:0] s2_tn  [NE];
  logic signed [2*COORD_BITS+2:0] s2_p1  [NE];
  logic signed [2*COORD_BITS+2:0] s2_p2  [NE];

  segbox_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .rx_o    (s1_rx),
    .ry_o    (s1_ry),
    .a_o     (s1_a),
    .b_o     (s1_b),
    .k_o     (s1_k),
    .qx_o    (s1_qx),
    .qy_o    (s1_qy)
  );

  segbox_mul #(
    .COORD_BITS(COORD_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .rx_i    (s1_rx),
    .ry_i    (s1_ry),
    .a_i     (s1_a),
    .b_i     (s1_b),
    .k_i     (s1_k),
    .qx_i    (s1_qx),
    .qy_i    (s1_qy),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .den_o   (s2_den),
    .tn_o    (s2_tn),
    .p1_o    (s2_p1),
    .p2_o    (s2_p2)
  );

  segbox_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .den_i   (s2_den),
    .tn_i    (s2_tn),
    .p1_i    (s2_p1),
    .p2_i    (s2_p2),
    .out_o   (out_o)
  );

endmodule

### src/segbox_prep.sv
// Stage 1: box corners, segment and offset vectors, per-edge multiplier operands.
// Depends on segbox_pkg and segbox_in_if.
module segbox_prep #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  segbox_in_if.sink                    in_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic signed [COORD_BITS:0]   rx_o,
  output logic signed [COORD_BITS:0]   ry_o,
  output logic signed [COORD_BITS:0]   a_o  [segbox_pkg::NUM_EDGES],
  output logic signed [COORD_BITS+1:0] b_o  [segbox_pkg::NUM_EDGES],
  output logic signed [COORD_BITS:0]   k_o  [segbox_pkg::NUM_EDGES],
  output logic signed [COORD_BITS+1:0] qx_o [segbox_pkg::NUM_EDGES],
  output logic signed [COORD_BITS+1:0] qy_o [segbox_pkg::NUM_EDGES]
);

  localparam int RW = COORD_BITS + 1;
  localparam int QW = COORD_BITS + 2;
  localparam int NE = segbox_pkg::NUM_EDGES;

  logic signed [QW-1:0] ax, ay, bx, by, px, py, hw, hh;
  logic signed [QW-1:0] xr, xl, yt, yb;
  logic signed [QW-1:0] cx [NE];
  logic signed [QW-1:0] cy [NE];
  logic signed [RW-1:0] rx_d, ry_d;
  logic signed [RW-1:0] a_d  [NE];
  logic signed [QW-1:0] b_d  [NE];
  logic signed [RW-1:0] k_d  [NE];
  logic signed [QW-1:0] qx_d [NE];
  logic signed [QW-1:0] qy_d [NE];
  logic signed [RW-1:0] rx_q, ry_q;
  logic signed [RW-1:0] a_q  [NE];
  logic signed [QW-1:0] b_q  [NE];
  logic signed [RW-1:0] k_q  [NE];
  logic signed [QW-1:0] qx_q [NE];
  logic signed [QW-1:0] qy_q [NE];
  logic                 valid_q;
  logic                 adv;

  assign ax = QW'(in_i.seg_start_x);
  assign ay = QW'(in_i.seg_start_y);
  assign bx = QW'(in_i.seg_end_x);
  assign by = QW'(in_i.seg_end_y);
  assign px = QW'(in_i.box_center_x);
  assign py = QW'(in_i.box_center_y);
  assign hw = $signed(QW'(in_i.box_half_w));
  assign hh = $signed(QW'(in_i.box_half_h));

  assign xr = px + hw;
  assign xl = px - hw;
  assign yt = py + hh;
  assign yb = py - hh;

  assign rx_d = RW'(bx - ax);
  assign ry_d = RW'(by - ay);

  always_comb begin
    cx[segbox_pkg::EDGE_RIGHT]  = xr;
    cy[segbox_pkg::EDGE_RIGHT]  = yt;
    cx[segbox_pkg::EDGE_BOTTOM] = xr;
    cy[segbox_pkg::EDGE_BOTTOM] = yb;
    cx[segbox_pkg::EDGE_LEFT]   = xl;
    cy[segbox_pkg::EDGE_LEFT]   = yb;
    cx[segbox_pkg::EDGE_TOP]    = xr;
    cy[segbox_pkg::EDGE_TOP]    = yt;
    k_d[segbox_pkg::EDGE_RIGHT]  = RW'(-(hh + hh));
    k_d[segbox_pkg::EDGE_BOTTOM] = RW'(hw + hw);
    k_d[segbox_pkg::EDGE_LEFT]   = RW'(hh + hh);
    k_d[segbox_pkg::EDGE_TOP]    = RW'(hw + hw);
  end

  for (genvar e = 0; e < NE; e++) begin : g_edge
    localparam logic VERT = segbox_pkg::edge_is_vertical(segbox_pkg::edge_e'(e));
    assign qx_d[e] = cx[e] - ax;
    assign qy_d[e] = cy[e] - ay;
    assign a_d[e]  = VERT ? rx_d : ry_d;
    assign b_d[e]  = VERT ? qx_d[e] : qy_d[e];
  end

  assign adv     = !valid_q || ready_i;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      a_q  <= a_d;
      b_q  <= b_d;
      k_q  <= k_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  assign valid_o = valid_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign k_o     = k_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;

endmodule

### src/segbox_mul.sv
// Stage 2: exact cross-product terms per edge (denominator, t numerator, u terms).
// Depends on segbox_pkg for the edge count.
module segbox_mul #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [COORD_BITS:0]     rx_i,
  input  logic signed [COORD_BITS:0]     ry_i,
  input  logic signed [COORD_BITS:0]     a_i  [segbox_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS+1:0]   b_i  [segbox_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS:0]     k_i  [segbox_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS+1:0]   qx_i [segbox_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS+1:0]   qy_i [segbox_pkg::NUM_EDGES],
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [2*COORD_BITS+1:0] den_o [segbox_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+2:0] tn_o  [segbox_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+2:0] p1_o  [segbox_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+2:0] p2_o  [segbox_pkg::NUM_EDGES]
);

  localparam int DW = 2 * COORD_BITS + 2;
  localparam int TW = 2 * COORD_BITS + 3;
  localparam int NE = segbox_pkg::NUM_EDGES;

  logic signed [DW-1:0] den_d [NE];
  logic signed [TW-1:0] tn_d  [NE];
  logic signed [TW-1:0] p1_d  [NE];
  logic signed [TW-1:0] p2_d  [NE];
  logic signed [DW-1:0] den_q [NE];
  logic signed [TW-1:0] tn_q  [NE];
  logic signed [TW-1:0] p1_q  [NE];
  logic signed [TW-1:0] p2_q  [NE];
  logic                 valid_q;
  logic                 adv;

  for (genvar e = 0; e < NE; e++) begin : g_edge
    assign den_d[e] = DW'(a_i[e]) * DW'(k_i[e]);
    assign tn_d[e]  = TW'(b_i[e]) * TW'(k_i[e]);
    assign p1_d[e]  = TW'(qx_i[e]) * TW'(ry_i);
    assign p2_d[e]  = TW'(qy_i[e]) * TW'(rx_i);
  end

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      den_q <= den_d;
      tn_q  <= tn_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign tn_o    = tn_q;
  assign p1_o    = p1_q;
  assign p2_o    = p2_q;

endmodule

### src/segbox_cmp.sv
// Stage 3: u numerator, closed-interval parameter tests, edge OR, result register.
// Depends on segbox_pkg and segbox_out_if.
module segbox_cmp #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [2*COORD_BITS+1:0] den_i [segbox_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+2:0] tn_i  [segbox_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+2:0] p1_i  [segbox_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+2:0] p2_i  [segbox_pkg::NUM_EDGES],
  segbox_out_if.source                   out_o
);

  localparam int UW = 2 * COORD_BITS + 4;
  localparam int NE = segbox_pkg::NUM_EDGES;

  function automatic logic in_unit(logic signed [UW-1:0] num, logic signed [UW-1:0] den);
    logic ok;
    priority if (den > 0) begin
      ok = (num >= 0) && (num <= den);
    end else if (den < 0) begin
      ok = (num <= 0) && (num >= den);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  logic signed [UW-1:0] den_w [NE];
  logic signed [UW-1:0] tn_w  [NE];
  logic signed [UW-1:0] un_w  [NE];
  logic [NE-1:0]        edge_hit;
  logic                 hit_d;
  logic                 hit_q;
  logic                 valid_q;
  logic                 adv;

  for (genvar e = 0; e < NE; e++) begin : g_edge
    assign den_w[e]    = UW'(den_i[e]);
    assign tn_w[e]     = UW'(tn_i[e]);
    assign un_w[e]     = UW'(p1_i[e]) - UW'(p2_i[e]);
    assign edge_hit[e] = in_unit(tn_w[e], den_w[e]) && in_unit(un_w[e], den_w[e]);
  end

  assign hit_d   = |edge_hit;
  assign adv     = !valid_q || out_o.ready;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      hit_q <= hit_d;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.hit   = hit_q;

endmodule

### verif/segment_box_edge_intersect_top_test.sv
// Self-checking testbench for segment_box_edge_intersect_top: a directed table, then
// random segment-box beats with random idling on both channels, checked in order.
// Depends on segbox_pkg, segbox_if and the RTL under src.
`timescale 1ns / 1ps

module segment_box_edge_intersect_top_test;

  localparam int COORD_BITS    = 16;
  localparam int N_DIRECTED    = 18;
  localparam int N_RANDOM      = 732;
  localparam int N_TAIL        = 100;
  localparam int USE_PREDICTOR = -1;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_sx;
    logic signed [COORD_BITS-1:0] seg_sy;
    logic signed [COORD_BITS-1:0] seg_ex;
    logic signed [COORD_BITS-1:0] seg_ey;
    logic signed [COORD_BITS-1:0] box_cx;
    logic signed [COORD_BITS-1:0] box_cy;
    logic        [COORD_BITS-2:0] box_hw;
    logic        [COORD_BITS-2:0] box_hh;
  } pair_t;

  typedef struct {
    logic hit;
    int   pair_no;
  } hit_entry_t;

  logic clk_i;
  logic rst_ni;

  segbox_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
  segbox_out_if                           out_if ();

  segment_box_edge_intersect_top #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  hit_entry_t hit_expected[$];
  bit         quiet_tail;
  int         pairs_sent;
  int         hits_seen;
  int         beats_seen;
  int         mismatch_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", hit_expected.size());
    $display("segment_box_edge_intersect_top_test: done, errors");
    $finish;
  end

  function automatic logic [COORD_BITS-1:0] to_coord(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic pair_t make_pair(int sx, int sy, int ex, int ey,
                                      int cx, int cy, int hw, int hh);
    pair_t p;
    p.seg_sx = to_coord(sx);
    p.seg_sy = to_coord(sy);
    p.seg_ex = to_coord(ex);
    p.seg_ey = to_coord(ey);
    p.box_cx = to_coord(cx);
    p.box_cy = to_coord(cy);
    p.box_hw = hw[COORD_BITS-2:0];
    p.box_hh = hh[COORD_BITS-2:0];
    return p;
  endfunction

  // num/den within [0,1], compared without division; zero den never passes
  function automatic logic ratio_in_unit(longint num, longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    if (den < 0) return (num <= 0) && (num >= den);
    return 1'b0;
  endfunction

  function automatic logic box_edge_crossed(pair_t p);
    longint            ax, ay, bx, by, px, py, hw, hh;
    longint            cx, cy, dx, dy, rx, ry, sx, sy, qx, qy;
    longint            den, tn, un;
    segbox_pkg::edge_e e;
    logic              crossed;
    ax = p.seg_sx;
    ay = p.seg_sy;
    bx = p.seg_ex;
    by = p.seg_ey;
    px = p.box_cx;
    py = p.box_cy;
    hw = p.box_hw;
    hh = p.box_hh;
    crossed = 1'b0;
    for (int k = 0; k < segbox_pkg::NUM_EDGES; k++) begin
      e = segbox_pkg::edge_e'(k);
      case (e)
        segbox_pkg::EDGE_RIGHT: begin
          cx = px + hw; cy = py + hh; dx = px + hw; dy = py - hh;
        end
        segbox_pkg::EDGE_BOTTOM: begin
          cx = px + hw; cy = py - hh; dx = px - hw; dy = py - hh;
        end
        segbox_pkg::EDGE_LEFT: begin
          cx = px - hw; cy = py - hh; dx = px - hw; dy = py + hh;
        end
        default: begin
          cx = px + hw; cy = py + hh; dx = px - hw; dy = py + hh;
        end
      endcase
      rx = bx - ax; ry = by - ay;
      sx = dx - cx; sy = dy - cy;
      qx = cx - ax; qy = cy - ay;
      den = rx * sy - ry * sx;
      tn  = qx * sy - qy * sx;
      un  = qx * ry - qy * rx;
      if (ratio_in_unit(tn, den) && ratio_in_unit(un, den)) crossed = 1'b1;
    end
    return crossed;
  endfunction

  // directed table: returns the hit read off by hand, or USE_PREDICTOR
  function automatic int directed_row(int idx, output pair_t p);
    case (idx)
      0: begin p = make_pair(-100, 0, 100, 0, 0, 0, 50, 50); return 1; end
      1: begin p = make_pair(10, 0, 10, 0, 0, 0, 10, 10); return 0; end
      2: begin p = make_pair(-10, 0, 10, 0, 0, 0, 50, 50); return 0; end
      3: begin p = make_pair(-100, 0, 100, 0, 0, 0, 0, 0); return 0; end
      4: begin p = make_pair(-100, 50, 100, 50, 0, 0, 50, 50); return 1; end
      5: begin p = make_pair(-100, 0, -50, 0, 0, 0, 50, 50); return 1; end
      6: begin
        p = make_pair(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767);
        return 1;
      end
      7: begin
        p = make_pair(-32768, 32767, -32768, -32768, 32767, 32767, 32767, 0);
        return 0;
      end
      8: begin
        p = make_pair(32767, 32767, -32768, 32767, -32768, -32768, 32767, 32767);
        return 0;
      end
      9: begin
        p = make_pair(32767, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
        return USE_PREDICTOR;
      end
      10: begin
        p = make_pair(-32768, 32767, 32767, -32768, -32768, 32767, 32767, 0);
        return USE_PREDICTOR;
      end
      11: begin p = make_pair(0, 0, 0, 0, -32768, -32768, 0, 0); return 0; end
      12: begin
        p = make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0);
        return 0;
      end
      13: begin
        p = make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        return 0;
      end
      14: begin p = make_pair(-1, -1, 1, 1, 0, 0, 1, 1); return USE_PREDICTOR; end
      15: begin p = make_pair(0, -200, 0, 200, 0, 0, 0, 100); return 0; end
      16: begin p = make_pair(3, -7, -5, 9, 1, 2, 4, 3); return USE_PREDICTOR; end
      default: begin
        p = make_pair(-200, -1, 200, 1, 0, 0, 100, 0);
        return USE_PREDICTOR;
      end
    endcase
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly segments near a small box, so hits and touches are frequent
  function automatic pair_t random_pair();
    int mode, cx, cy, hw, hh, sx, sy, ex, ey, reach;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      return make_pair(rand_span(-32768, 32767), rand_span(-32768, 32767),
                       rand_span(-32768, 32767), rand_span(-32768, 32767),
                       rand_span(-32768, 32767), rand_span(-32768, 32767),
                       rand_span(0, 32767), rand_span(0, 32767));
    end
    cx = rand_span(-30000, 30000);
    cy = rand_span(-30000, 30000);
    hw = rand_span(0, 2000);
    hh = rand_span(0, 2000);
    reach = hw + hh + 500;
    sx = cx + rand_span(-reach, reach);
    sy = cy + rand_span(-reach, reach);
    ex = cx + rand_span(-reach, reach);
    ey = cy + rand_span(-reach, reach);
    case (mode)
      7: begin
        if ($urandom_range(0, 1) != 0) ey = sy;
        else ex = sx;
      end
      8: begin
        sx = ($urandom_range(0, 1) != 0) ? cx + hw : cx - hw;
        sy = cy + rand_span(-hh, hh);
      end
      9: begin
        case ($urandom_range(0, 2))
          0: begin ex = sx; ey = sy; end
          1: hw = 0;
          default: hh = 0;
        endcase
      end
      default: ;
    endcase
    return make_pair(sx, sy, ex, ey, cx, cy, hw, hh);
  endfunction

  task automatic send_pair(input pair_t p, input int want);
    int         gap;
    hit_entry_t entry;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.seg_start_x  <= p.seg_sx;
    in_if.seg_start_y  <= p.seg_sy;
    in_if.seg_end_x    <= p.seg_ex;
    in_if.seg_end_y    <= p.seg_ey;
    in_if.box_center_x <= p.box_cx;
    in_if.box_center_y <= p.box_cy;
    in_if.box_half_w   <= p.box_hw;
    in_if.box_half_h   <= p.box_hh;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    entry.hit     = (want == USE_PREDICTOR) ? box_edge_crossed(p) : want[0];
    entry.pair_no = pairs_sent;
    hit_expected.push_back(entry);
    pairs_sent++;
  endtask

  initial begin : stimulus
    pair_t p;
    int    want;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.seg_start_x  <= '0;
    in_if.seg_start_y  <= '0;
    in_if.seg_end_x    <= '0;
    in_if.seg_end_y    <= '0;
    in_if.box_center_x <= '0;
    in_if.box_center_y <= '0;
    in_if.box_half_w   <= '0;
    in_if.box_half_h   <= '0;
    quiet_tail   = 1'b0;
    pairs_sent   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int idx = 0; idx < N_DIRECTED; idx++) begin
      want = directed_row(idx, p);
      send_pair(p, want);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      quiet_tail = (k >= N_RANDOM - N_TAIL);
      send_pair(random_pair(), USE_PREDICTOR);
    end
    in_if.valid <= 1'b0;
    while (hit_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("%0d segment-box pairs (%0d from the directed table), %0d hit beats of %0d",
             pairs_sent, N_DIRECTED, hits_seen, beats_seen);
    $display("both channels idled in bursts; the last %0d pairs ran back to back", N_TAIL);
    if (mismatch_cnt == 0) begin
      $display("segment_box_edge_intersect_top_test: done, clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("segment_box_edge_intersect_top_test: done, errors");
    end
    $finish;
  end

  initial begin : result_check
    int         stall;
    hit_entry_t entry;
    out_if.ready <= 1'b0;
    stall        = 0;
    mismatch_cnt = 0;
    hits_seen    = 0;
    beats_seen   = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        beats_seen++;
        if (out_if.hit === 1'b1) hits_seen++;
        if (hit_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result beat, hit=%b", out_if.hit);
        end else begin
          entry = hit_expected.pop_front();
          if (out_if.hit !== entry.hit) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("pair %0d: hit expected %b, got %b",
                       entry.pair_no, entry.hit, out_if.hit);
          end
        end
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        stall = $urandom_range(1, 12) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

endmodule

### files.f
src/segbox_pkg.sv
src/segbox_if.sv
src/segbox_prep.sv
src/segbox_mul.sv
src/segbox_cmp.sv
src/segment_box_edge_intersect_top.sv
verif/segment_box_edge_intersect_top_test.sv
